>>> rtl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg - host command slave shared definitions
// Event codes, command codes, task codes, register map and the result type.
// ----------------------------------------------------------------------------
package hcs_pkg;

    // default size of one ping-pong buffer in bytes
    localparam int BUF_BYTES_DEF = 256;

    // configuration port
    localparam int CFG_AW = 3;
    localparam logic REG_IC_VERSION = 1'b0;
    localparam logic REG_IDLE_READ  = 1'b1;

    // bus event codes
    localparam logic [2:0] OP_WRITE     = 3'd0;
    localparam logic [2:0] OP_READ_DONE = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_FILL      = 3'd3;
    localparam logic [2:0] OP_CHECK     = 3'd4;

    // host commands
    localparam logic [7:0] CMD_PING     = 8'h01;
    localparam logic [7:0] CMD_READ     = 8'h03;
    localparam logic [7:0] CMD_RESET    = 8'h07;
    localparam logic [7:0] CMD_MODE     = 8'h09;
    localparam logic [7:0] CMD_INT      = 8'h10;
    localparam logic [7:0] CMD_CLR_A    = 8'h55;
    localparam logic [7:0] CMD_ERASE    = 8'h61;
    localparam logic [7:0] CMD_CLR_C    = 8'h64;
    localparam logic [7:0] CMD_CHECKSUM = 8'h65;
    localparam logic [7:0] CMD_CHECK_B  = 8'h66;
    localparam logic [7:0] CMD_STATUS   = 8'h6A;
    localparam logic [7:0] CMD_ID       = 8'h90;
    localparam logic [7:0] CMD_CLR_B    = 8'hAA;
    localparam logic [7:0] CMD_WRITE    = 8'hBF;
    localparam logic [7:0] CMD_CHECK_A  = 8'hCC;
    localparam logic [7:0] CMD_VERSION  = 8'hF5;

    // chip ID and reset mode
    localparam logic [7:0] ID_HIGH      = 8'h88;
    localparam logic [7:0] ID_LOW       = 8'hA6;
    localparam logic [7:0] MODE_UPGRADE = 8'h0B;

    // flash task codes
    localparam logic [2:0] TASK_NONE     = 3'd0;
    localparam logic [2:0] TASK_WRITE    = 3'd1;
    localparam logic [2:0] TASK_READ     = 3'd2;
    localparam logic [2:0] TASK_CHECKSUM = 3'd3;
    localparam logic [2:0] TASK_ERASE    = 3'd4;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [2:0]  task_code;
        logic        task_buffer;
        logic [23:0] task_addr;
        logic [15:0] task_len;
        logic        reset_req;
        logic [7:0]  download_mode;
        logic [7:0]  erase_pages;
        logic [7:0]  int_mode;
    } hcs_result_t;

endpackage

>>> rtl/hcs_buf_ram.sv
// ----------------------------------------------------------------------------
// hcs_buf_ram - ping-pong buffer store
// Byte-wide synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hcs_buf_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] buf_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            buf_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= buf_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/host_command_slave.sv
// ----------------------------------------------------------------------------
// host_command_slave - bootloader host command decoder
// An accepted item passes stage 0, stage 1 and the output register to the master side.
// Throughput: 1 item per cycle while m_tready holds; the buffer RAM read of
//   stage 0 is registered alongside stage 1, so nothing stalls short of m_tready.
// Reset: rst_n clears all control state; mode starts as upgrade mode.
//   The buffer RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Stage 0 decodes the bus event against the register state (command, index,
// checksum, header arrays) and updates it in the same cycle. Payload and fill
// bytes are written to the RAM there; a buffer read for command 0x03 is issued
// there too. No item reads an entry that it writes itself, and writes of
// earlier items landed at earlier edges, so the RAM needs no forwarding.
// Stage 1 holds the decoded result while the RAM answers; the output register
// then merges the RAM byte in and faces the master side.
// ----------------------------------------------------------------------------
module host_command_slave #(
    parameter int BUF_BYTES = hcs_pkg::BUF_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [7:0] data, [15:8] fill_index, [31:16] flash_status
    input  logic [31:0]                s_tdata,
    // [2:0] op
    input  logic [2:0]                 s_tuser,
    // result items
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] tx_byte, [10:8] task_code, [11] task_buffer, [35:12] task_addr,
    // [51:36] task_len, [52] reset_req, [60:53] download_mode,
    // [68:61] erase_pages, [76:69] int_mode, [79:77] zero
    output logic [79:0]                m_tdata,
    // [0] tx_valid
    output logic                       m_tuser,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hcs_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import hcs_pkg::*;

    localparam int PW    = $clog2(BUF_BYTES);   // position within one buffer
    localparam int DEPTH = 2 * BUF_BYTES;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // 8-bit position modulo BUF_BYTES; for buffers of 16 to 255 bytes the quotient
    // is below 16, so four compare-and-subtract steps finish the job
    function automatic logic [PW-1:0] pos8_slot(input logic [7:0] v);
        logic [11:0] r;
        r = {4'd0, v};
        if (BUF_BYTES >= 256)
        begin
            return PW'(v);
        end
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 12'(BUF_BYTES << k))
            begin
                r = r - 12'(BUF_BYTES << k);
            end
        end
        return PW'(r);
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic b, input logic [PW-1:0] p);
        return b ? (AW'(BUF_BYTES) + AW'(p)) : AW'(p);
    endfunction

    // address header: bytes 1..3 build the 24-bit start address
    function automatic logic [23:0] hdr_addr(input logic [7:0] idx, input logic [7:0] d,
                                             input logic [23:0] old);
        logic [23:0] r;
        r = old;
        if (idx == 8'd1)
        begin
            r = {d, 16'd0};
        end
        else if (idx == 8'd2)
        begin
            r = old + {8'd0, d, 8'd0};
        end
        else if (idx == 8'd3)
        begin
            r = old + {16'd0, d};
        end
        return r;
    endfunction

    // length header: bytes 4..5 build the 16-bit length
    function automatic logic [15:0] hdr_len(input logic [7:0] idx, input logic [7:0] d,
                                            input logic [15:0] old);
        logic [15:0] r;
        r = old;
        if (idx == 8'd4)
        begin
            r = {d, 8'd0};
        end
        else if (idx == 8'd5)
        begin
            r = old + {8'd0, d};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------------
    logic [2:0]  in_op;
    logic [7:0]  in_data;
    logic [7:0]  in_fidx;
    logic [15:0] in_status;

    assign in_op     = s_tuser;
    assign in_data   = s_tdata[7:0];
    assign in_fidx   = s_tdata[15:8];
    assign in_status = s_tdata[31:16];

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [7:0] ver_reg;
    logic [7:0] idle_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_IDLE_READ) ? {24'd0, idle_reg} : {24'd0, ver_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg  <= 8'd0;
            idle_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_IDLE_READ)
            begin
                idle_reg <= pwdata[7:0];
            end
            else
            begin
                ver_reg <= pwdata[7:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command state
    // ------------------------------------------------------------------------
    logic [7:0]    bi_reg,    bi_next;      // byte index within the transfer
    logic [7:0]    cmd_reg,   cmd_next;
    logic [7:0]    xor_reg,   xor_next;     // running checksum
    logic          nbs_reg,   nbs_next;     // buffer for the next transfer
    logic          act_reg,   act_next;     // buffer in use
    logic [23:0]   addr_reg   [2];
    logic [23:0]   addr_next  [2];
    logic [15:0]   len_reg    [2];
    logic [15:0]   len_next   [2];
    logic [15:0]   wpos_reg   [2];
    logic [15:0]   wpos_next  [2];
    logic [PW-1:0] wslot_reg  [2];          // wpos modulo BUF_BYTES
    logic [PW-1:0] wslot_next [2];
    logic [7:0]    mode_reg,  mode_next;
    logic [7:0]    erase_reg, erase_next;
    logic [7:0]    int_reg,   int_next;

    // pipeline
    logic          s1_valid_reg;
    hcs_result_t   s1_res_reg;
    logic          s1_mem_reg;              // reply byte comes from RAM
    hcs_result_t   s1_res_merged;           // stage 1 result with RAM byte in
    logic          out_valid_reg;
    hcs_result_t   out_res_reg;
    logic          s1_move;
    logic          accept;

    // RAM
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    hcs_result_t   res;
    logic          use_mem;

    assign s1_move  = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | s1_move;
    assign accept   = s_tvalid & s_tready;

    // ------------------------------------------------------------------------
    // Stage 0: event decode and state update
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]  idx;
        logic [7:0]  cmd;
        logic [7:0]  ridx;
        logic        a;
        logic        armed;
        logic [15:0] wpos_inc;

        bi_next    = bi_reg;
        cmd_next   = cmd_reg;
        xor_next   = xor_reg;
        nbs_next   = nbs_reg;
        act_next   = act_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        wpos_next  = wpos_reg;
        wslot_next = wslot_reg;
        mode_next  = mode_reg;
        erase_next = erase_reg;
        int_next   = int_reg;
        res        = '0;
        mem_we     = 1'b0;
        mem_waddr  = slot_addr(act_reg, pos8_slot(in_fidx));
        armed      = 1'b0;
        ridx       = 8'd0;
        idx        = bi_reg;
        cmd        = cmd_reg;
        a          = act_reg;
        wpos_inc   = wpos_reg[act_reg] + 16'd1;

        unique case (in_op)
            OP_WRITE:
            begin
                if (idx == 8'd0)
                begin
                    cmd = in_data;
                end
                cmd_next = cmd;
                bi_next  = bi_reg + 8'd1;
                case (cmd) inside
                    CMD_CLR_A, CMD_CLR_B, CMD_CLR_C:
                    begin
                        xor_next = 8'd0;
                    end
                    CMD_ID:
                    begin
                        if (idx < 8'd4)
                        begin
                            xor_next = 8'd0;
                        end
                        armed = (idx == 8'd0);
                    end
                    CMD_WRITE:
                    begin
                        if (idx != 8'd0)
                        begin
                            if (idx == 8'd1)
                            begin
                                act_next = nbs_reg;
                            end
                            a        = act_next;
                            wpos_inc = wpos_reg[a] + 16'd1;
                            if (idx <= 8'd5)
                            begin
                                addr_next[a] = hdr_addr(idx, in_data, addr_reg[a]);
                                len_next[a]  = hdr_len(idx, in_data, len_reg[a]);
                                if (idx == 8'd5)
                                begin
                                    wpos_next[a]  = 16'd0;
                                    wslot_next[a] = '0;
                                end
                            end
                            else
                            begin
                                // payload byte
                                xor_next     = xor_reg ^ in_data;
                                mem_we       = 1'b1;
                                mem_waddr    = slot_addr(a, wslot_reg[a]);
                                wpos_next[a] = wpos_inc;
                                if (wpos_inc == 16'd0 || wslot_reg[a] == PW'(BUF_BYTES - 1))
                                begin
                                    wslot_next[a] = '0;
                                end
                                else
                                begin
                                    wslot_next[a] = wslot_reg[a] + PW'(1);
                                end
                                if (wpos_inc >= len_reg[a])
                                begin
                                    nbs_next        = ~nbs_reg;
                                    res.task_code   = TASK_WRITE;
                                    res.task_buffer = a;
                                    res.task_addr   = addr_reg[a];
                                    res.task_len    = len_reg[a];
                                end
                            end
                        end
                    end
                    CMD_READ:
                    begin
                        if (idx == 8'd1)
                        begin
                            act_next = nbs_reg;
                        end
                        a = act_next;
                        if (idx >= 8'd1 && idx <= 8'd3)
                        begin
                            addr_next[a] = hdr_addr(idx, in_data, addr_reg[a]);
                        end
                        if (idx == 8'd3)
                        begin
                            armed           = 1'b1;
                            res.task_code   = TASK_READ;
                            res.task_buffer = a;
                            res.task_addr   = addr_next[a];
                            res.task_len    = len_reg[a];
                        end
                    end
                    CMD_RESET:
                    begin
                        res.reset_req = 1'b1;
                    end
                    CMD_MODE:
                    begin
                        if (idx == 8'd1)
                        begin
                            mode_next = in_data;
                        end
                        else if (idx == 8'd2)
                        begin
                            erase_next = in_data;
                        end
                    end
                    CMD_INT:
                    begin
                        // every byte, command byte included
                        int_next = in_data;
                    end
                    CMD_PING, CMD_CHECK_A, CMD_CHECK_B, CMD_STATUS, CMD_VERSION:
                    begin
                        armed = 1'b1;
                    end
                    CMD_CHECKSUM:
                    begin
                        if (idx >= 8'd1 && idx <= 8'd5)
                        begin
                            addr_next[a] = hdr_addr(idx, in_data, addr_reg[a]);
                            len_next[a]  = hdr_len(idx, in_data, len_reg[a]);
                        end
                        if (idx == 8'd5)
                        begin
                            res.task_code   = TASK_CHECKSUM;
                            res.task_buffer = a;
                            res.task_addr   = addr_next[a];
                            res.task_len    = len_next[a];
                        end
                    end
                    CMD_ERASE:
                    begin
                        res.task_code = TASK_ERASE;
                        xor_next      = 8'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_READ_DONE:
            begin
                bi_next = bi_reg + 8'd1;
                armed   = 1'b1;
                ridx    = bi_reg + 8'd1;
            end
            OP_STOP:
            begin
                bi_next = 8'd0;
            end
            OP_FILL:
            begin
                mem_we = 1'b1;
            end
            OP_CHECK:
            begin
                xor_next = xor_reg ^ in_data;
            end
            default:
            begin
            end
        endcase

        // reply byte, from the state as this item leaves it
        use_mem = 1'b0;
        if (armed)
        begin
            res.tx_valid = 1'b1;
            res.tx_byte  = idle_reg;
            case (cmd_next) inside
                CMD_ID:
                begin
                    if (ridx == 8'd0)
                    begin
                        res.tx_byte = ID_HIGH;
                    end
                    else if (ridx == 8'd1)
                    begin
                        res.tx_byte = ID_LOW;
                    end
                end
                CMD_READ:
                begin
                    res.tx_byte = 8'd0;
                    use_mem     = 1'b1;
                end
                CMD_CHECK_A, CMD_CHECK_B:
                begin
                    res.tx_byte = xor_next;
                end
                CMD_STATUS:
                begin
                    if (ridx == 8'd0)
                    begin
                        res.tx_byte = in_status[15:8];
                    end
                    else if (ridx == 8'd1)
                    begin
                        res.tx_byte = in_status[7:0];
                    end
                end
                CMD_VERSION:
                begin
                    if (ridx == 8'd0)
                    begin
                        res.tx_byte = ver_reg;
                    end
                    else if (ridx == 8'd1)
                    begin
                        res.tx_byte = ~ver_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        mem_raddr = slot_addr(act_next, pos8_slot(ridx));

        res.download_mode = mode_next;
        res.erase_pages   = erase_next;
        res.int_mode      = int_next;
    end

    hcs_buf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_buf_ram (
        .clk   (clk),
        .we    (accept & mem_we),
        .waddr (mem_waddr),
        .wdata (in_data),
        .re    (accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bi_reg    <= 8'd0;
            cmd_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            nbs_reg   <= 1'b0;
            act_reg   <= 1'b0;
            addr_reg  <= '{default: '0};
            len_reg   <= '{default: '0};
            wpos_reg  <= '{default: '0};
            wslot_reg <= '{default: '0};
            mode_reg  <= MODE_UPGRADE;
            erase_reg <= 8'd0;
            int_reg   <= 8'd0;
        end
        else if (accept)
        begin
            bi_reg    <= bi_next;
            cmd_reg   <= cmd_next;
            xor_reg   <= xor_next;
            nbs_reg   <= nbs_next;
            act_reg   <= act_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            wpos_reg  <= wpos_next;
            wslot_reg <= wslot_next;
            mode_reg  <= mode_next;
            erase_reg <= erase_next;
            int_reg   <= int_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 and output register
    // ------------------------------------------------------------------------
    // The RAM reads only on accept, and stage 1 blocks accept while it holds,
    // so mem_rdata stays put until stage 1 moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1 result with the RAM byte merged in for buffer reads
    always_comb
    begin
        s1_res_merged = s1_res_reg;
        if (s1_mem_reg)
        begin
            s1_res_merged.tx_byte = mem_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
            s1_mem_reg <= use_mem;
        end
        if (s1_move)
        begin
            out_res_reg <= s1_res_merged;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.tx_valid;
    assign m_tdata  = {3'd0,
                       out_res_reg.int_mode,
                       out_res_reg.erase_pages,
                       out_res_reg.download_mode,
                       out_res_reg.reset_req,
                       out_res_reg.task_len,
                       out_res_reg.task_addr,
                       out_res_reg.task_buffer,
                       out_res_reg.task_code,
                       out_res_reg.tx_byte};

endmodule
